@@ sv/qrs_pkg.sv @@
`default_nettype none
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_W          = 40;
    localparam int KIND_W         = 3;

    localparam logic [KIND_W-1:0] KIND_INF  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LIN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TWO  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DBL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CPX  = 3'd5;

endpackage
`default_nettype wire

@@ sv/qrs_front.sv @@
`default_nettype none
module qrs_front
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                ce,
    input  wire logic                                in_valid,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_c,
    output logic                                     out_valid,
    output logic [KIND_W-1:0]                        out_kind,
    output logic [2*COEF_WIDTH:0]                    out_dmag,
    output logic signed [COEF_WIDTH+FRAC_BITS:0]     out_n0,
    output logic signed [COEF_WIDTH+1:0]             out_den
);
    localparam int CW  = COEF_WIDTH;
    localparam int PW  = 2 * CW;
    localparam int DSW = 2 * CW + 3;
    localparam int NBW = CW + FRAC_BITS + 1;

    // stage 1: capture
    logic                 v1_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, c1_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [CW-1:0] a2_reg, b2_reg, c2_reg;
    logic [PW-1:0]        bb_reg;
    logic [PW-1:0]        ac_reg;
    logic [CW-1:0]        am, bm, cm;
    logic [PW-1:0]        bb_next, ac_next;

    // stage 3: discriminant and classification
    logic                  v3_reg;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [PW:0]           dmag_reg, dmag_next;
    logic signed [NBW-1:0] n0_reg, n0_next;
    logic signed [CW+1:0]  den_reg, den_next;
    logic signed [DSW-1:0] dsum;
    logic                  lin;

    always_comb begin
        am = a1_reg[CW-1] ? CW'(-a1_reg) : CW'(a1_reg);
        bm = b1_reg[CW-1] ? CW'(-b1_reg) : CW'(b1_reg);
        cm = c1_reg[CW-1] ? CW'(-c1_reg) : CW'(c1_reg);
        bb_next = PW'(bm) * PW'(bm);
        ac_next = PW'(am) * PW'(cm);
    end

    always_comb begin
        if (a2_reg[CW-1] ^ c2_reg[CW-1]) begin
            dsum = $signed(DSW'(bb_reg)) + $signed(DSW'({ac_reg, 2'b00}));
        end else begin
            dsum = $signed(DSW'(bb_reg)) - $signed(DSW'({ac_reg, 2'b00}));
        end
        dmag_next = dsum[DSW-1] ? (PW+1)'(-dsum) : (PW+1)'(dsum);
        lin = (a2_reg == '0);
        if (lin) begin
            if (b2_reg == '0) begin
                kind_next = (c2_reg == '0) ? KIND_INF : KIND_NONE;
            end else begin
                kind_next = KIND_LIN;
            end
        end else if (dsum == '0) begin
            kind_next = KIND_DBL;
        end else if (dsum[DSW-1]) begin
            kind_next = KIND_CPX;
        end else begin
            kind_next = KIND_TWO;
        end
        if (lin) begin
            n0_next  = -($signed(NBW'(c2_reg)) <<< FRAC_BITS);
            den_next = (CW+2)'(b2_reg);
        end else begin
            n0_next  = -($signed(NBW'(b2_reg)) <<< FRAC_BITS);
            den_next = $signed((CW+2)'(a2_reg)) <<< 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            bb_reg   <= bb_next;
            ac_reg   <= ac_next;
            kind_reg <= kind_next;
            dmag_reg <= dmag_next;
            n0_reg   <= n0_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_kind  = kind_reg;
    assign out_dmag  = dmag_reg;
    assign out_n0    = n0_reg;
    assign out_den   = den_reg;

endmodule
`default_nettype wire

@@ sv/qrs_sqrt.sv @@
`default_nettype none
module qrs_sqrt #(
    parameter int RW  = 66,
    parameter int SBW = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [RW-1:0]   in_rad,
    input  wire logic [SBW-1:0]  in_sb,
    output logic                 out_valid,
    output logic [RW/2-1:0]      out_root,
    output logic [SBW-1:0]       out_sb
);
    localparam int N = RW / 2;

    logic            v_reg    [N];
    logic [RW-1:0]   rad_reg  [N];
    logic [N+1:0]    rem_reg  [N];
    logic [N-1:0]    root_reg [N];
    logic [SBW-1:0]  sb_reg   [N];

    for (genvar k = 0; k < N; k++) begin : g_st
        logic            v_in;
        logic [RW-1:0]   rad_in;
        logic [N+1:0]    rem_in;
        logic [N-1:0]    root_in;
        logic [SBW-1:0]  sb_in;
        logic [N+2:0]    acc, trial, diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        assign acc   = {rem_in[N:0], rad_in[RW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (acc >= trial);
        assign diff  = acc - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= ge ? diff[N+1:0] : acc[N+1:0];
                root_reg[k] <= {root_in[N-2:0], ge};
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule
`default_nettype wire

@@ sv/qrs_div.sv @@
`default_nettype none
module qrs_div #(
    parameter int NW  = 34,
    parameter int DW  = 17,
    parameter int SBW = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [NW-1:0]   in_num,
    input  wire logic [DW-1:0]   in_den,
    input  wire logic [SBW-1:0]  in_sb,
    output logic                 out_valid,
    output logic [NW-1:0]        out_quo,
    output logic [SBW-1:0]       out_sb
);
    logic            v_reg   [NW];
    logic [NW-1:0]   num_reg [NW];
    logic [DW-1:0]   den_reg [NW];
    logic [DW-1:0]   rem_reg [NW];
    logic [NW-1:0]   quo_reg [NW];
    logic [SBW-1:0]  sb_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic            v_in;
        logic [NW-1:0]   num_in;
        logic [DW-1:0]   den_in;
        logic [DW-1:0]   rem_in;
        logic [NW-1:0]   quo_in;
        logic [SBW-1:0]  sb_in;
        logic [DW:0]     acc, diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign num_in = in_num;
            assign den_in = in_den;
            assign rem_in = '0;
            assign quo_in = '0;
            assign sb_in  = in_sb;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        assign acc  = {rem_in, num_in[NW-1]};
        assign ge   = (acc >= {1'b0, den_in});
        assign diff = acc - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                num_reg[k] <= num_in << 1;
                den_reg[k] <= den_in;
                rem_reg[k] <= ge ? diff[DW-1:0] : acc[DW-1:0];
                quo_reg[k] <= {quo_in[NW-2:0], ge};
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_sb    = sb_reg[NW-1];

endmodule
`default_nettype wire

@@ sv/quadratic_root_solver_unit.sv @@
// Quadratic root solver. Each request carries signed coefficients a, b, c and yields one
// result: the root kind (infinite, none, linear, two real, double, complex pair) and two
// signed 40-bit fixed point values with FRAC_BITS fraction bits, truncated toward zero
// and saturated. The unit is fully pipelined and accepts one request per clock while the
// output is not stalled. A request passes through the discriminant setup stages (capture,
// products, classification), COEF_WIDTH+FRAC_BITS+1 square root stages, one combine stage,
// COEF_WIDTH+FRAC_BITS+2 divider stages and one output register; the root and quotient
// pipelines resolve one bit per stage. A stalled result holds the whole pipeline.
`default_nettype none
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // coef_a, coef_b, coef_c
    input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // root_kind, first_value, second_value
    output logic [((KIND_W+2*OUT_W+7)/8)*8-1:0]         m_tdata
);
    localparam int CW   = COEF_WIDTH;
    localparam int NBW  = CW + FRAC_BITS + 1;
    localparam int RW   = 2 * CW + 2 * FRAC_BITS + 2;
    localparam int SW   = RW / 2;
    localparam int SBW  = KIND_W + NBW + CW + 2;
    localparam int NSW  = CW + FRAC_BITS + 3;
    localparam int NW   = CW + FRAC_BITS + 2;
    localparam int DW   = CW + 1;
    localparam int EW   = ((NW > OUT_W) ? NW : OUT_W) + 1;
    localparam int MW   = ((KIND_W + 2 * OUT_W + 7) / 8) * 8;

    logic ce;

    logic                  f_valid;
    logic [KIND_W-1:0]     f_kind;
    logic [2*CW:0]         f_dmag;
    logic signed [NBW-1:0] f_n0;
    logic signed [CW+1:0]  f_den;

    logic                  q_valid;
    logic [SW-1:0]         q_root;
    logic [SBW-1:0]        q_sb;
    logic [KIND_W-1:0]     q_kind;
    logic signed [NBW-1:0] q_n0;
    logic signed [CW+1:0]  q_den;

    logic                  cb_valid_reg;
    logic [KIND_W-1:0]     cb_kind_reg;
    logic [NW-1:0]         cb_mag1_reg, cb_mag2_reg, cb_mag1_next, cb_mag2_next;
    logic                  cb_neg1_reg, cb_neg2_reg, cb_neg1_next, cb_neg2_next;
    logic [DW-1:0]         cb_den_reg, cb_den_next;
    logic signed [NSW-1:0] num1, num2, n0x, sx;

    logic                  d1_valid, d2_valid;
    logic [NW-1:0]         d1_quo, d2_quo;
    logic [KIND_W:0]       d1_sb;
    logic                  d2_sb;

    logic                  m_valid_reg;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [OUT_W-1:0]      first_reg, second_reg, first_next, second_next;

    function automatic logic [OUT_W-1:0] sat_val(input logic [NW-1:0] q, input logic neg);
        logic signed [EW-1:0] qs;
        logic signed [EW-1:0] maxv;
        logic signed [EW-1:0] minv;
        maxv = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        minv = {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
        qs = neg ? -$signed(EW'(q)) : $signed(EW'(q));
        if (qs > maxv) begin
            qs = maxv;
        end else if (qs < minv) begin
            qs = minv;
        end
        return qs[OUT_W-1:0];
    endfunction

    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .coef_a    (s_tdata[CW-1:0]),
        .coef_b    (s_tdata[2*CW-1:CW]),
        .coef_c    (s_tdata[3*CW-1:2*CW]),
        .out_valid (f_valid),
        .out_kind  (f_kind),
        .out_dmag  (f_dmag),
        .out_n0    (f_n0),
        .out_den   (f_den)
    );

    qrs_sqrt #(
        .RW  (RW),
        .SBW (SBW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_rad    ({1'b0, f_dmag, {(2*FRAC_BITS){1'b0}}}),
        .in_sb     ({f_kind, f_n0, f_den}),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_sb    (q_sb)
    );

    assign {q_kind, q_n0, q_den} = q_sb;

    always_comb begin
        n0x  = NSW'(q_n0);
        sx   = $signed(NSW'(q_root));
        num1 = '0;
        num2 = '0;
        unique case (q_kind)
            KIND_LIN, KIND_DBL: begin
                num1 = n0x;
            end
            KIND_TWO: begin
                num1 = n0x + sx;
                num2 = n0x - sx;
            end
            KIND_CPX: begin
                num1 = n0x;
                num2 = sx;
            end
            default: begin
                num1 = '0;
            end
        endcase
        cb_neg1_next = num1[NSW-1] ^ q_den[CW+1];
        cb_neg2_next = num2[NSW-1] ^ q_den[CW+1];
        cb_mag1_next = num1[NSW-1] ? NW'(-num1) : NW'(num1);
        cb_mag2_next = num2[NSW-1] ? NW'(-num2) : NW'(num2);
        cb_den_next  = q_den[CW+1] ? DW'(-q_den) : DW'(q_den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_valid_reg <= 1'b0;
        end else if (ce) begin
            cb_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cb_kind_reg <= q_kind;
            cb_mag1_reg <= cb_mag1_next;
            cb_mag2_reg <= cb_mag2_next;
            cb_neg1_reg <= cb_neg1_next;
            cb_neg2_reg <= cb_neg2_next;
            cb_den_reg  <= cb_den_next;
        end
    end

    qrs_div #(
        .NW  (NW),
        .DW  (DW),
        .SBW (KIND_W + 1)
    ) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (cb_valid_reg),
        .in_num    (cb_mag1_reg),
        .in_den    (cb_den_reg),
        .in_sb     ({cb_kind_reg, cb_neg1_reg}),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_sb    (d1_sb)
    );

    qrs_div #(
        .NW  (NW),
        .DW  (DW),
        .SBW (1)
    ) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (cb_valid_reg),
        .in_num    (cb_mag2_reg),
        .in_den    (cb_den_reg),
        .in_sb     (cb_neg2_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_sb    (d2_sb)
    );

    always_comb begin
        kind_next   = d1_sb[KIND_W:1];
        first_next  = sat_val(d1_quo, d1_sb[0]);
        second_next = sat_val(d2_quo, d2_sb);
        if (kind_next == KIND_INF || kind_next == KIND_NONE) begin
            first_next  = '0;
            second_next = '0;
        end else if (kind_next == KIND_LIN || kind_next == KIND_DBL) begin
            second_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            kind_reg   <= kind_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MW'({second_reg, first_reg, kind_reg});

    a_no_root_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_reg == KIND_INF || kind_reg == KIND_NONE)
            |-> first_reg == '0 && second_reg == '0)
        else $error("no-root result carries nonzero value");

    a_single_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_reg == KIND_LIN || kind_reg == KIND_DBL) |-> second_reg == '0)
        else $error("single-root result carries second value");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        d1_valid == d2_valid)
        else $error("divider pipelines out of step");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import qrs_pkg::*;

    localparam int CW      = COEF_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int SDW     = ((3*CW+7)/8)*8;
    localparam int MDW     = ((KIND_W+2*OUT_W+7)/8)*8;
    localparam int LATENCY = 2*CW + 2*FB + 8;
    localparam int N_RAND  = 1800;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] a;
    } coefs_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] second;
        logic signed [OUT_W-1:0] first;
        logic [KIND_W-1:0]       kind;
    } roots_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDW-1:0] m_tdata;

    coefs_t pending_coefs[$];
    roots_t expected_roots[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     held_off = 0;
    bit     feeding_done = 1'b0;

    quadratic_root_solver_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [OUT_W-1:0] clamp40(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (OUT_W-1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[OUT_W-1:0];
        if (v < lo) return lo[OUT_W-1:0];
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(input coefs_t q);
        roots_t r;
        logic signed [127:0] a, b, c, d, nb, den, s;
        a = q.a; b = q.b; c = q.c;
        r = '0;
        if (a == 0) begin
            if (b == 0) begin
                r.kind = (c == 0) ? KIND_INF : KIND_NONE;
            end else begin
                r.kind  = KIND_LIN;
                r.first = clamp40((-c * (128'sd1 <<< FB)) / b);
            end
        end else begin
            d   = b*b - 4*a*c;
            nb  = -b * (128'sd1 <<< FB);
            den = 2*a;
            if (d == 0) begin
                r.kind  = KIND_DBL;
                r.first = clamp40(nb / den);
            end else begin
                s = $signed(isqrt((d < 0 ? -d : d) <<< (2*FB)));
                if (d > 0) begin
                    r.kind   = KIND_TWO;
                    r.first  = clamp40((nb + s) / den);
                    r.second = clamp40((nb - s) / den);
                end else begin
                    r.kind   = KIND_CPX;
                    r.first  = clamp40(nb / den);
                    r.second = clamp40(s / den);
                end
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 55) return 0;
        if (p < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic signed [CW-1:0] rand_coef();
        int p;
        p = int'($urandom_range(0, 9));
        if (p < 4) return CW'(int'($urandom_range(0, 15)) - 8);
        if (p < 5) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (p < 7) return CW'(int'($urandom_range(0, 511)) - 256);
        return CW'($urandom);
    endfunction

    task automatic push_req(input int a, input int b, input int c);
        coefs_t q;
        q.a = CW'(a); q.b = CW'(b); q.c = CW'(c);
        pending_coefs.push_back(q);
    endtask

    initial begin
        int k, r1, r2;
        push_req(0, 0, 0);
        push_req(0, 0, 7);
        push_req(0, 3, -7);
        push_req(0, -32768, 32767);
        push_req(0, 1, -32768);
        push_req(1, -3, 2);
        push_req(-1, 3, -2);
        push_req(1, 2, 1);
        push_req(4, -4, 1);
        push_req(1, 0, 1);
        push_req(-2, 2, -5);
        push_req(32767, 32767, 32767);
        push_req(-32768, -32768, -32768);
        push_req(-32768, 32767, 32767);
        push_req(1, -32768, -32768);
        push_req(1, 32767, 0);
        push_req(-1, -32768, 0);
        push_req(1, 0, 0);
        push_req(-32768, 0, 1);
        push_req(32767, -1, 0);
        push_req(1, -32768, 32767);
        for (int i = 0; i < N_RAND; i++) begin
            k = int'($urandom_range(0, 9));
            if (k == 0) begin
                r1 = int'($urandom_range(0, 31)) - 16;
                r2 = int'($urandom_range(0, 31)) - 16;
                k = int'($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
                push_req(k, -k*(r1+r2), k*r1*r2);
            end else if (k == 1) begin
                push_req(0, rand_coef(), rand_coef());
            end else begin
                push_req(rand_coef(), rand_coef(), rand_coef());
            end
        end
        feeding_done = 1'b1;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_roots.push_back(solve_roots(coefs_t'(s_tdata[3*CW-1:0])));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_coefs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= SDW'(pending_coefs.pop_front());
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (held_off < 300) begin
                held_off <= held_off + 1;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        roots_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = roots_t'(m_tdata[KIND_W+2*OUT_W-1:0]);
            if (expected_roots.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_roots.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.first !== want.first)
                    $display("%0t first exp %0d got %0d", $time, want.first, got.first);
                if (got.second !== want.second)
                    $display("%0t second exp %0d got %0d", $time, want.second, got.second);
                if (got !== want) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("[quadratic_root_solver_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        wait (feeding_done);
        @(posedge aclk);
        while (pending_coefs.size() > 0 || s_tvalid || expected_roots.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("[quadratic_root_solver_unit] OK");
        end else begin
            $display("[quadratic_root_solver_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
